// ===== rtl/stp_pkg.sv =====
// shared types, constants and helpers of the string to integer parser
`default_nettype none

package stp_pkg;

  localparam int unsigned OffsetBitsDefault = 16;
  localparam int unsigned EndOffsetBits     = 16;
  localparam logic [5:0]  RadixReset        = 6'd10;

  localparam logic [5:0] BaseMin = 6'd2;
  localparam logic [5:0] BaseMax = 6'd36;
  localparam logic [5:0] Base16  = 6'd16;
  localparam logic [5:0] Base10  = 6'd10;
  localparam logic [5:0] Base8   = 6'd8;
  localparam logic [5:0] NoDigit = 6'd63;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;
  localparam logic [7:0] CharLoA   = 8'h61;
  localparam logic [7:0] CharLoZ   = 8'h7A;
  localparam logic [7:0] CharUpX   = 8'h58;
  localparam logic [7:0] CharLoX   = 8'h78;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;

  localparam logic [63:0] MagPosLimit = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MagNegLimit = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_RANGE    = 2'd1,
    STATUS_BAD_BASE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MUL_CUR = 2'd0,
    MUL_16  = 2'd1,
    MUL_10  = 2'd2,
    MUL_8   = 2'd3
  } mul_sel_e;

  typedef enum logic [1:0] {
    BASE_KEEP   = 2'd0,
    BASE_SET_16 = 2'd1,
    BASE_SET_10 = 2'd2,
    BASE_SET_8  = 2'd3
  } base_set_e;

  // character classification and base compares, datapath to controller
  typedef struct packed {
    logic radix_bad;
    logic is_ws;
    logic is_minus;
    logic is_plus;
    logic is_zero;
    logic is_x;
    logic base_zero;
    logic base_16;
    logic dig_lt_base;
    logic dig_lt_10;
    logic dig_lt_8;
    logic dig_lt_16;
  } dp_stat_t;

  // controller commands to the datapath
  typedef struct packed {
    logic      step;
    logic      clear;
    logic      set_neg;
    logic      accept;
    mul_sel_e  mul_sel;
    base_set_e base_set;
    logic      result_invalid;
  } dp_cmd_t;

  typedef struct packed {
    logic [63:0]              mag;
    logic                     neg;
    logic [EndOffsetBits-1:0] end_offset;
    logic                     digits;
    status_e                  status;
  } result_t;

  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = {2'b00, NoDigit};
    if (c inside {[CharZero:CharNine]}) begin
      d = c - CharZero;
    end else if (c inside {[CharUpA:CharUpZ]}) begin
      d = c - CharUpA + 8'd10;
    end else if (c inside {[CharLoA:CharLoZ]}) begin
      d = c - CharLoA + 8'd10;
    end
    return d[5:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/stp_ctrl.sv =====
// parse phase state machine of the string to integer parser
`default_nettype none

module stp_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic             last_i,
  input  wire stp_pkg::dp_stat_t stat_i,
  output stp_pkg::dp_cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    PH_WS      = 7'b0000001,
    PH_FIRST   = 7'b0000010,
    PH_ZERO    = 7'b0000100,
    PH_PREFIX  = 7'b0001000,
    PH_DIGITS  = 7'b0010000,
    PH_DONE    = 7'b0100000,
    PH_INVALID = 7'b1000000
  } phase_e;

  phase_e phase_q, phase_d;
  logic   tf_zero, tf_ok, do_first;

  always_comb begin
    tf_zero  = stat_i.is_zero && (stat_i.base_zero || stat_i.base_16);
    tf_ok    = stat_i.base_zero ? stat_i.dig_lt_10 : stat_i.dig_lt_base;
    do_first = 1'b0;
    phase_d  = phase_q;

    cmd_o.step           = step_i;
    cmd_o.clear          = step_i && last_i;
    cmd_o.set_neg        = 1'b0;
    cmd_o.accept         = 1'b0;
    cmd_o.mul_sel        = stp_pkg::MUL_CUR;
    cmd_o.base_set       = stp_pkg::BASE_KEEP;
    cmd_o.result_invalid = 1'b0;

    if (step_i) begin
      if (stat_i.radix_bad) begin
        phase_d = PH_INVALID;
      end else begin
        case (phase_q)
          PH_WS: begin
            if (stat_i.is_ws) begin
              phase_d = PH_WS;
            end else if (stat_i.is_minus) begin
              cmd_o.set_neg = 1'b1;
              phase_d       = PH_FIRST;
            end else if (stat_i.is_plus) begin
              phase_d = PH_FIRST;
            end else begin
              do_first = 1'b1;
            end
          end
          PH_FIRST: do_first = 1'b1;
          PH_ZERO: begin
            if (stat_i.is_x) begin
              cmd_o.base_set = stp_pkg::BASE_SET_16;
              phase_d        = PH_PREFIX;
            end else if (stat_i.base_zero) begin
              cmd_o.base_set = stp_pkg::BASE_SET_8;
              cmd_o.mul_sel  = stp_pkg::MUL_8;
              cmd_o.accept   = stat_i.dig_lt_8;
              phase_d        = stat_i.dig_lt_8 ? PH_DIGITS : PH_DONE;
            end else begin
              cmd_o.accept = stat_i.dig_lt_base;
              phase_d      = stat_i.dig_lt_base ? PH_DIGITS : PH_DONE;
            end
          end
          PH_PREFIX: begin
            cmd_o.mul_sel = stp_pkg::MUL_16;
            cmd_o.accept  = stat_i.dig_lt_16;
            phase_d       = stat_i.dig_lt_16 ? PH_DIGITS : PH_DONE;
          end
          PH_DIGITS: begin
            cmd_o.accept = stat_i.dig_lt_base;
            phase_d      = stat_i.dig_lt_base ? PH_DIGITS : PH_DONE;
          end
          default: phase_d = phase_q;
        endcase

        // first character after white space or sign
        if (do_first) begin
          if (tf_zero) begin
            cmd_o.accept  = 1'b1;
            cmd_o.mul_sel = stp_pkg::MUL_16;
            phase_d       = PH_ZERO;
          end else begin
            if (stat_i.base_zero) begin
              cmd_o.base_set = stp_pkg::BASE_SET_10;
              cmd_o.mul_sel  = stp_pkg::MUL_10;
            end
            cmd_o.accept = tf_ok;
            phase_d      = tf_ok ? PH_DIGITS : PH_DONE;
          end
        end
      end
    end

    cmd_o.result_invalid = (phase_d == PH_INVALID);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WS;
    end else if (cmd_o.clear) begin
      phase_q <= PH_WS;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/stp_datapath.sv =====
// accumulator, base, position and radix register of the string to integer parser
`default_nettype none

module stp_datapath #(
  parameter int unsigned OFFSET_BITS = stp_pkg::OffsetBitsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [5:0]        cfg_radix_i,
  input  wire logic [7:0]        char_i,
  input  wire stp_pkg::dp_cmd_t  cmd_i,
  output stp_pkg::dp_stat_t      stat_o,
  output stp_pkg::result_t       result_o
);

  localparam int unsigned EndW = (OFFSET_BITS > stp_pkg::EndOffsetBits) ?
                                 OFFSET_BITS : stp_pkg::EndOffsetBits;
  localparam logic [OFFSET_BITS-1:0] PosMax = {OFFSET_BITS{1'b1}};

  logic [5:0]             radix_q;
  logic                   neg_q, neg_d;
  logic [63:0]            acc_q, acc_d;
  logic                   ovf_q, ovf_d;
  logic [5:0]             base_q, base_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] end_q, end_d;
  logic                   any_q, any_d;

  logic                   first, radix_ok;
  logic [5:0]             base_now, digit, mul;
  logic [69:0]            prod;
  logic [70:0]            sum;
  logic [63:0]            limit;
  logic                   over;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [EndW-1:0]        end_wide;

  assign first    = (pos_q == '0);
  assign radix_ok = (radix_q == '0) || (radix_q inside {[stp_pkg::BaseMin:stp_pkg::BaseMax]});
  assign base_now = first ? radix_q : base_q;
  assign digit    = stp_pkg::digit_of(char_i);

  always_comb begin
    stat_o.radix_bad   = first && !radix_ok;
    stat_o.is_ws       = (char_i == stp_pkg::CharSpace) ||
                         (char_i inside {[stp_pkg::CharTab:stp_pkg::CharCr]});
    stat_o.is_minus    = (char_i == stp_pkg::CharMinus);
    stat_o.is_plus     = (char_i == stp_pkg::CharPlus);
    stat_o.is_zero     = (char_i == stp_pkg::CharZero);
    stat_o.is_x        = (char_i == stp_pkg::CharLoX) || (char_i == stp_pkg::CharUpX);
    stat_o.base_zero   = (base_now == '0);
    stat_o.base_16     = (base_now == stp_pkg::Base16);
    stat_o.dig_lt_base = (digit < base_now);
    stat_o.dig_lt_10   = (digit < stp_pkg::Base10);
    stat_o.dig_lt_8    = (digit < stp_pkg::Base8);
    stat_o.dig_lt_16   = (digit < stp_pkg::Base16);
  end

  always_comb begin
    case (cmd_i.mul_sel)
      stp_pkg::MUL_16: mul = stp_pkg::Base16;
      stp_pkg::MUL_10: mul = stp_pkg::Base10;
      stp_pkg::MUL_8:  mul = stp_pkg::Base8;
      default:         mul = base_now;
    endcase
  end

  // overflow exactly when acc * base + digit exceeds the limit for the sign
  assign prod  = {6'b0, acc_q} * {64'b0, mul};
  assign sum   = {1'b0, prod} + {65'b0, digit};
  assign limit = neg_q ? stp_pkg::MagNegLimit : stp_pkg::MagPosLimit;
  assign over  = (sum > {7'b0, limit});

  assign pos_inc = (pos_q == PosMax) ? pos_q : pos_q + OFFSET_BITS'(1);

  always_comb begin
    neg_d  = neg_q;
    acc_d  = acc_q;
    ovf_d  = ovf_q;
    base_d = base_q;
    pos_d  = pos_q;
    end_d  = end_q;
    any_d  = any_q;
    if (cmd_i.step) begin
      pos_d  = pos_inc;
      base_d = base_now;
      case (cmd_i.base_set)
        stp_pkg::BASE_SET_16: base_d = stp_pkg::Base16;
        stp_pkg::BASE_SET_10: base_d = stp_pkg::Base10;
        stp_pkg::BASE_SET_8:  base_d = stp_pkg::Base8;
        default:              base_d = base_now;
      endcase
      if (cmd_i.set_neg) begin
        neg_d = 1'b1;
      end
      if (cmd_i.accept) begin
        any_d = 1'b1;
        end_d = pos_inc;
        if (!ovf_q) begin
          if (over) begin
            ovf_d = 1'b1;
            acc_d = limit;
          end else begin
            acc_d = sum[63:0];
          end
        end
      end
    end
  end

  assign end_wide = EndW'(end_d);

  always_comb begin
    result_o.mag        = acc_d;
    result_o.neg        = neg_d;
    result_o.digits     = any_d;
    result_o.end_offset = (end_wide > EndW'({stp_pkg::EndOffsetBits{1'b1}})) ?
                          {stp_pkg::EndOffsetBits{1'b1}} :
                          end_wide[stp_pkg::EndOffsetBits-1:0];
    if (cmd_i.result_invalid) begin
      result_o.status = stp_pkg::STATUS_BAD_BASE;
    end else if (ovf_d) begin
      result_o.status = stp_pkg::STATUS_RANGE;
    end else begin
      result_o.status = stp_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= stp_pkg::RadixReset;
    end else if (cfg_we_i) begin
      radix_q <= cfg_radix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q  <= 1'b0;
      acc_q  <= '0;
      ovf_q  <= 1'b0;
      base_q <= '0;
      pos_q  <= '0;
      end_q  <= '0;
      any_q  <= 1'b0;
    end else if (cmd_i.clear) begin
      neg_q  <= 1'b0;
      acc_q  <= '0;
      ovf_q  <= 1'b0;
      base_q <= '0;
      pos_q  <= '0;
      end_q  <= '0;
      any_q  <= 1'b0;
    end else begin
      neg_q  <= neg_d;
      acc_q  <= acc_d;
      ovf_q  <= ovf_d;
      base_q <= base_d;
      pos_q  <= pos_d;
      end_q  <= end_d;
      any_q  <= any_d;
    end
  end

`ifndef ASSERT_OFF
  a_ovf_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (acc_q == limit))
    else $error("overflow flag set but accumulator not at its limit");
  a_end_not_past_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_q <= pos_q)
    else $error("parse end beyond current position");
  a_no_digit_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !any_q |-> (acc_q == '0 && end_q == '0 && !ovf_q))
    else $error("accumulator or end position set without any digit");
  a_clear_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (pos_q == '0 && !any_q && !neg_q))
    else $error("string state not cleared after last transaction");
`endif

endmodule

`default_nettype wire

// ===== rtl/stp_outreg.sv =====
// result register with valid and ready toward the consumer
`default_nettype none

module stp_outreg (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                load_i,
  input  wire stp_pkg::result_t                    result_i,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output logic signed [63:0]                       value_o,
  output logic [stp_pkg::EndOffsetBits-1:0]        end_offset_o,
  output logic                                     digits_found_o,
  output logic [1:0]                               status_o
);

  logic             valid_q;
  stp_pkg::result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  // sign applied after the register, keeps the multiply path short
  assign out_valid_o    = valid_q;
  assign value_o        = res_q.neg ? -$signed(res_q.mag) : $signed(res_q.mag);
  assign end_offset_o   = res_q.end_offset;
  assign digits_found_o = res_q.digits;
  assign status_o       = res_q.status;

endmodule

`default_nettype wire

// ===== rtl/string_to_integer_parser.sv =====
// top level of the streaming string to integer parser
//
//   channel  direction  signals                                   payload
//   cfg      in         cfg_valid_i / cfg_ready_o                 cfg_radix_i
//   in       in         in_valid_i / in_ready_o                   char_code_i, last_char_i
//   out      out        out_valid_o / out_ready_i                 value_o, end_offset_o,
//                                                                 digits_found_o, status_o
//
// one character per cycle while in_ready_o is high; the 64 by 6 multiply-accumulate with overflow check
// in the datapath sets that figure
// the result is registered and appears in the cycle after the character marked last is taken
// reset sets the radix to 10 and starts a fresh string, no clearing pass
// in_ready_o drops only while a result waits and out_ready_i is low
`default_nettype none

module string_to_integer_parser #(
  parameter int unsigned OFFSET_BITS = stp_pkg::OffsetBitsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [5:0]                   cfg_radix_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [7:0]                   char_code_i,
  input  wire logic                         last_char_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [63:0]                value_o,
  output logic [stp_pkg::EndOffsetBits-1:0] end_offset_o,
  output logic                              digits_found_o,
  output logic [1:0]                        status_o
);

  logic              step;
  stp_pkg::dp_cmd_t  cmd;
  stp_pkg::dp_stat_t stat;
  stp_pkg::result_t  result;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_o || out_ready_i;
  assign step        = in_valid_i && in_ready_o;

  stp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .last_i (last_char_i),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  stp_datapath #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_radix_i (cfg_radix_i),
    .char_i      (char_code_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .result_o    (result)
  );

  stp_outreg u_outreg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (cmd.clear),
    .result_i       (result),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .value_o        (value_o),
    .end_offset_o   (end_offset_o),
    .digits_found_o (digits_found_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire
